// ----- rtl/core/raster_blur_3x3_top_defines.svh -----
// Assertion macros for the raster blur block.
`ifndef RASTER_BLUR_3X3_TOP_DEFINES_SVH
`define RASTER_BLUR_3X3_TOP_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define RBLUR_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("raster_blur_3x3: assertion failed");

// Check that cons holds in the cycle after ante.
`define RBLUR_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("raster_blur_3x3: assertion failed");

`endif

// ----- rtl/core/rblur_pkg.sv -----
// Shared constants and register codes of the raster blur block.
package rblur_pkg;

  localparam int unsigned SAMPLE_BITS = 16;
  localparam int unsigned MAX_COLUMNS = 1024;
  localparam int unsigned MIN_SIZE    = 3;

  localparam int unsigned COL_W    = $clog2(MAX_COLUMNS);
  localparam int unsigned ROW_W    = 16;
  localparam int unsigned NUMCOL_W = 11;
  localparam int unsigned CEFF_W   = $clog2(MAX_COLUMNS + 1);
  localparam int unsigned CMP_W    = (NUMCOL_W > CEFF_W) ? NUMCOL_W : CEFF_W;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  // Kernel sums: 16 times a sample at most for the gaussian.
  localparam int unsigned SUM_W       = SAMPLE_BITS + 4;
  localparam int unsigned GAUSS_SHIFT = 4;

  // Divide by 6 as multiply by a rounded-up reciprocal; exact for |sum| < 2**ABS_W.
  localparam int unsigned ABS_W     = SAMPLE_BITS + 2;
  localparam int unsigned DIV_SHIFT = ABS_W + 3;
  localparam int unsigned RECIP_W   = DIV_SHIFT - 2;
  localparam int unsigned PROD_W    = ABS_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'd1 << DIV_SHIFT) / 64'd6 + 64'd1);

  // Results one input can cause: two columns, up to three rows each.
  localparam int unsigned RUN_SLOTS = 6;

  localparam logic [COL_W-1:0] C_LAST_RESET = COL_W'(MAX_COLUMNS - 1);
  localparam logic [ROW_W-1:0] R_LAST_RESET = ROW_W'(63);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE        = 2'd0,
    REG_NUM_COLUMNS = 2'd1,
    REG_NUM_ROWS    = 2'd2
  } cfg_reg_e;

endpackage

// ----- rtl/core/rblur_ram.sv -----
// Generic single-clock RAM with one write port and one registered read port.
module rblur_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

endmodule

// ----- rtl/core/raster_blur_3x3_top.sv -----
// Top level of the raster blur block: streaming 3x3 smoothing of a signed raster.
//
// Samples enter one per transfer in row order and leave as smoothed results tagged with
// row and column, one result per transfer. The block takes one sample per clock while the
// output is not stalled and each sample causes at most one result, which is every sample
// of an interior row except the last of the row; a sample that causes several results holds
// the run register until it has sent them all, so the single result port sets the rate
// (two results per sample on the first and last computed rows, four at their row ends, up
// to six at a row end of a three-row raster). From acceptance to the first result a sample
// passes the line memory read, the kernel sum, the reciprocal multiply for cross mode and
// the result register. Two line memories of MAX_COLUMNS entries hold the two previous rows;
// each entry is read once and written back once per sample, never by two samples at once.
// They are not cleared after reset: the first two rows of a raster must arrive before any
// computed row uses them. Writing num_columns or num_rows restarts the raster at row 0,
// column 0; configuration is to be written only while the block holds no sample.
`include "raster_blur_3x3_top_defines.svh"

module raster_blur_3x3_top
  import rblur_pkg::*;
(
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]          cfg_index_i,
  input  logic [CFG_DATA_W-1:0]         cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [ROW_W-1:0]              row_o,
  output logic [COL_W-1:0]              column_o,
  output logic signed [SAMPLE_BITS-1:0] value_o,
  output logic                          last_of_run_o,
  output logic                          end_of_frame_o
);

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [SUM_W-1:0]       sum_t;

  // What one sample will emit, carried down the pipeline.
  typedef struct packed {
    logic [COL_W-1:0]     col_a;
    logic [ROW_W-1:0]     row_x;
    logic [RUN_SLOTS-1:0] slots;
    logic                 zero_val;
    logic                 eof;
  } run_info_t;

  // Slot order within a run: column a rows (0, x, last), then column C-1 likewise.
  localparam int unsigned SLOT_B_FIRST = 3;
  localparam int unsigned SLOT_ROW0_A  = 0;
  localparam int unsigned SLOT_LAST_A  = 2;
  localparam int unsigned SLOT_ROW0_B  = 3;
  localparam int unsigned SLOT_LAST_B  = 5;

  // ---------------------------------------------------------------------------
  // Configuration registers and raster position
  // ---------------------------------------------------------------------------
  logic             cfg_we;
  logic             accept;
  logic             restart;
  logic             mode_q, mode_d;
  logic [COL_W-1:0] c_last_q, c_last_d;
  logic [ROW_W-1:0] r_last_q, r_last_d;
  logic [COL_W-1:0] col_cnt_q, col_cnt_d;
  logic [ROW_W-1:0] row_cnt_q, row_cnt_d;
  logic [CMP_W-1:0] raw_cols;
  logic [ROW_W-1:0] raw_rows;
  logic             at_col_end;
  logic             at_row_end;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i & cfg_ready_o;
  assign accept      = in_valid_i & ~in_stall_o;
  assign raw_cols    = CMP_W'(cfg_data_i[NUMCOL_W-1:0]);
  assign raw_rows    = cfg_data_i[ROW_W-1:0];
  assign at_col_end  = (col_cnt_q == c_last_q);
  assign at_row_end  = (row_cnt_q == r_last_q);

  // Hold the effective last column and last row rather than the raw counts.
  always_comb begin
    mode_d   = mode_q;
    c_last_d = c_last_q;
    r_last_d = r_last_q;
    restart  = 1'b0;
    if (cfg_we) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_MODE: begin
          mode_d = cfg_data_i[0];
        end
        REG_NUM_COLUMNS: begin
          restart = 1'b1;
          if (raw_cols < CMP_W'(MIN_SIZE)) begin
            c_last_d = COL_W'(MIN_SIZE - 1);
          end else if (raw_cols > CMP_W'(MAX_COLUMNS)) begin
            c_last_d = COL_W'(MAX_COLUMNS - 1);
          end else begin
            c_last_d = COL_W'(raw_cols - CMP_W'(1));
          end
        end
        REG_NUM_ROWS: begin
          restart = 1'b1;
          if (raw_rows < ROW_W'(MIN_SIZE)) begin
            r_last_d = ROW_W'(MIN_SIZE - 1);
          end else begin
            r_last_d = raw_rows - ROW_W'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Advance the raster position per accepted sample; wrap at the end of the raster; restart clears it.
  always_comb begin
    col_cnt_d = col_cnt_q;
    row_cnt_d = row_cnt_q;
    if (restart) begin
      col_cnt_d = '0;
      row_cnt_d = '0;
    end else if (accept) begin
      if (at_col_end) begin
        col_cnt_d = '0;
        row_cnt_d = at_row_end ? '0 : row_cnt_q + ROW_W'(1);
      end else begin
        col_cnt_d = col_cnt_q + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= 1'b0;
      c_last_q  <= C_LAST_RESET;
      r_last_q  <= R_LAST_RESET;
      col_cnt_q <= '0;
      row_cnt_q <= '0;
    end else begin
      mode_q    <= mode_d;
      c_last_q  <= c_last_d;
      r_last_q  <= r_last_d;
      col_cnt_q <= col_cnt_d;
      row_cnt_q <= row_cnt_d;
    end
  end

  // Work out at acceptance which results this sample will cause. Rows 0 and 1 and
  // column 1 cause none; the first computed row also stands for row 0, the last for R-1.
  run_info_t s0_info;
  logic      rows_ok;
  logic      has_a;
  logic      has_b;
  logic      is_first;

  assign rows_ok  = (row_cnt_q >= ROW_W'(2));
  assign has_a    = rows_ok & (col_cnt_q != COL_W'(1));
  assign has_b    = rows_ok & at_col_end;
  assign is_first = (row_cnt_q == ROW_W'(2));

  always_comb begin
    s0_info.col_a    = (col_cnt_q == '0) ? '0 : col_cnt_q - COL_W'(1);
    s0_info.row_x    = row_cnt_q - ROW_W'(1);
    s0_info.slots    = {has_b & at_row_end, has_b, has_b & is_first,
                        has_a & at_row_end, has_a, has_a & is_first};
    s0_info.zero_val = (col_cnt_q == '0);
    s0_info.eof      = at_col_end & at_row_end;
  end

  // ---------------------------------------------------------------------------
  // Pipeline flow control: stage 1 line read, stage 2 kernel sum, stage 3 quotient,
  // then the run register that feeds the output.
  // ---------------------------------------------------------------------------
  logic s1_v_q, s2_v_q, s3_v_q, job_v_q;
  logic s1_move, s2_move, s3_go, job_load, job_free;
  logic s1_ready, s2_ready, s3_ready;
  logic out_xfer, run_last;

  run_info_t s1_info_q, s2_info_q, s3_info_q;

  assign out_xfer = job_v_q & ~out_stall_i;
  assign job_free = ~job_v_q | (out_xfer & run_last);
  // Drop a sample that causes no result here; it has already updated the line memories.
  assign s3_go    = s3_v_q & ((s3_info_q.slots == '0) | job_free);
  assign job_load = s3_v_q & (s3_info_q.slots != '0) & job_free;
  assign s3_ready = ~s3_v_q | s3_go;
  assign s2_move  = s2_v_q & s3_ready;
  assign s2_ready = ~s2_v_q | s2_move;
  assign s1_move  = s1_v_q & s2_ready;
  assign s1_ready = ~s1_v_q | s1_move;

  assign in_stall_o = ~s1_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      s3_v_q  <= 1'b0;
      job_v_q <= 1'b0;
    end else begin
      s1_v_q  <= accept | (s1_v_q & ~s1_move);
      s2_v_q  <= s1_move | (s2_v_q & ~s2_move);
      s3_v_q  <= s2_move | (s3_v_q & ~s3_go);
      job_v_q <= job_load | (job_v_q & ~(out_xfer & run_last));
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: line memories and window. Read at acceptance, write back as the sample
  // leaves stage 1. Successive samples use distinct columns, so no entry is read and
  // written in the same cycle.
  // ---------------------------------------------------------------------------
  logic [COL_W-1:0] s1_col_q;
  sample_t          s1_bot_q;
  sample_t          top;
  sample_t          mid;
  sample_t          win_q [3][2];

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_info_q <= s0_info;
      s1_col_q  <= col_cnt_q;
      s1_bot_q  <= sample_i;
    end
  end

  rblur_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (MAX_COLUMNS)
  ) u_line_older (
    .clk_i     (clk_i),
    .wr_en_i   (s1_move),
    .wr_addr_i (s1_col_q),
    .wr_data_i (mid),
    .rd_en_i   (accept),
    .rd_addr_i (col_cnt_q),
    .rd_data_o (top)
  );

  rblur_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (MAX_COLUMNS)
  ) u_line_newer (
    .clk_i     (clk_i),
    .wr_en_i   (s1_move),
    .wr_addr_i (s1_col_q),
    .wr_data_i (s1_bot_q),
    .rd_en_i   (accept),
    .rd_addr_i (col_cnt_q),
    .rd_data_o (mid)
  );

  // Shift the window one column left for every sample, whatever its row.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        win_q[i][0] <= '0;
        win_q[i][1] <= '0;
      end
    end else if (s1_move) begin
      for (int i = 0; i < 3; i++) begin
        win_q[i][1] <= win_q[i][0];
      end
      win_q[0][0] <= top;
      win_q[1][0] <= mid;
      win_q[2][0] <= s1_bot_q;
    end
  end

  // Kernel sums over the 3x3 neighbourhood; tap[i][j] is row i, column j left to right.
  sum_t tap [3][3];
  sum_t gauss_sum;
  sum_t cross_sum;
  sum_t s2_sum_d, s2_sum_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      tap[i][0] = SUM_W'(win_q[i][1]);
      tap[i][1] = SUM_W'(win_q[i][0]);
    end
    tap[0][2] = SUM_W'(top);
    tap[1][2] = SUM_W'(mid);
    tap[2][2] = SUM_W'(s1_bot_q);

    gauss_sum = tap[0][0] + (tap[0][1] <<< 1) + tap[0][2]
              + (tap[1][0] <<< 1) + (tap[1][1] <<< 2) + (tap[1][2] <<< 1)
              + tap[2][0] + (tap[2][1] <<< 1) + tap[2][2];
    cross_sum = tap[0][1] + tap[1][0] + (tap[1][1] <<< 1) + tap[1][2] + tap[2][1];
    s2_sum_d  = mode_q ? cross_sum : gauss_sum;
  end

  always_ff @(posedge clk_i) begin
    if (s1_move) begin
      s2_info_q <= s1_info_q;
      s2_sum_q  <= s2_sum_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: gaussian by arithmetic shift (floor); cross by magnitude times the
  // reciprocal of 6, sign restored when the run register loads (truncation to zero).
  // ---------------------------------------------------------------------------
  logic                   s2_neg;
  logic [SUM_W-1:0]       s2_mag;
  logic [PROD_W-1:0]      s2_prod;
  logic [SAMPLE_BITS-1:0] s3_quot_q;
  logic                   s3_neg_q;
  logic [SAMPLE_BITS-1:0] s3_gauss_q;

  assign s2_neg  = s2_sum_q[SUM_W-1];
  assign s2_mag  = s2_neg ? -s2_sum_q : s2_sum_q;
  assign s2_prod = PROD_W'(s2_mag[ABS_W-1:0]) * PROD_W'(RECIP);

  always_ff @(posedge clk_i) begin
    if (s2_move) begin
      s3_info_q  <= s2_info_q;
      s3_quot_q  <= s2_prod[PROD_W-1:DIV_SHIFT];
      s3_neg_q   <= s2_neg;
      s3_gauss_q <= s2_sum_q[SUM_W-1:GAUSS_SHIFT];
    end
  end

  // ---------------------------------------------------------------------------
  // Run register: one entry per sample, emptied one slot per output transfer.
  // ---------------------------------------------------------------------------
  logic [RUN_SLOTS-1:0]   job_slots_q, job_slots_d;
  logic [COL_W-1:0]       job_col_q;
  logic [ROW_W-1:0]       job_row_x_q;
  logic [SAMPLE_BITS-1:0] job_val_q, job_val_d;
  logic                   job_eof_q;
  logic [RUN_SLOTS-1:0]   cur_slot;
  logic [RUN_SLOTS-1:0]   rest_slots;
  logic                   use_b;

  always_comb begin
    if (s3_info_q.zero_val) begin
      job_val_d = '0;
    end else if (mode_q) begin
      job_val_d = s3_neg_q ? -s3_quot_q : s3_quot_q;
    end else begin
      job_val_d = s3_gauss_q;
    end
  end

  // Emit the lowest pending slot first.
  assign cur_slot   = job_slots_q & (~job_slots_q + RUN_SLOTS'(1));
  assign rest_slots = job_slots_q & ~cur_slot;
  assign run_last   = (rest_slots == '0);
  assign use_b      = |cur_slot[SLOT_B_FIRST +: 3];

  always_comb begin
    job_slots_d = job_slots_q;
    if (job_load) begin
      job_slots_d = s3_info_q.slots;
    end else if (out_xfer) begin
      job_slots_d = rest_slots;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      job_slots_q <= '0;
    end else begin
      job_slots_q <= job_slots_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (job_load) begin
      job_col_q   <= s3_info_q.col_a;
      job_row_x_q <= s3_info_q.row_x;
      job_val_q   <= job_val_d;
      job_eof_q   <= s3_info_q.eof;
    end
  end

  // Drive the result from the run register; it holds while the output is stalled.
  always_comb begin
    if (cur_slot[SLOT_ROW0_A] | cur_slot[SLOT_ROW0_B]) begin
      row_o = '0;
    end else if (cur_slot[SLOT_LAST_A] | cur_slot[SLOT_LAST_B]) begin
      row_o = r_last_q;
    end else begin
      row_o = job_row_x_q;
    end
  end

  assign out_valid_o    = job_v_q;
  assign column_o       = use_b ? c_last_q : job_col_q;
  assign value_o        = use_b ? '0 : job_val_q;
  assign last_of_run_o  = run_last;
  assign end_of_frame_o = job_eof_q & run_last;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `RBLUR_ASSERT_IMP(a_run_not_empty, job_v_q, job_slots_q != '0)
  `RBLUR_ASSERT_NXT(a_run_continues, out_valid_o && !out_stall_i && !last_of_run_o, out_valid_o)
  `RBLUR_ASSERT_NXT(a_raster_wraps, accept && at_col_end && at_row_end, col_cnt_q == '0 && row_cnt_q == '0)

endmodule
